// ===== design/tpcs_pkg.sv =====
// Shared types and constants for the two-process scheduler tick block.
package tpcs_pkg;

    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_POLICY       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANTUM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CPU_A  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IO_A         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CPU_A = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CPU_B  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IO_B         = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_CPU_B = 3'd7;

    // Scheduling policies
    localparam logic [1:0] POL_FCFS = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_SRTF = 2'd2;
    localparam logic [1:0] POL_RR   = 2'd3;

    // Process state codes
    localparam logic [1:0] ST_READY = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Register reset values
    localparam logic [1:0] RST_POLICY  = POL_FCFS;
    localparam logic [7:0] RST_QUANTUM = 8'd1;
    localparam logic [7:0] RST_CPU     = 8'd1;
    localparam logic [7:0] RST_IO      = 8'd0;

    typedef logic [1:0] t_pstate;

    typedef struct packed {
        logic [1:0] policy;
        logic [7:0] quantum;
        logic [7:0] first_cpu_a;
        logic [7:0] io_a;
        logic [7:0] second_cpu_a;
        logic [7:0] first_cpu_b;
        logic [7:0] io_b;
        logic [7:0] second_cpu_b;
    } t_cfg;

    typedef struct packed {
        logic restart;
    } t_in;

    typedef struct packed {
        t_pstate code_a;
        t_pstate code_b;
        logic    all_done;
    } t_out;

endpackage

// ===== design/tpcs_chan_if.sv =====
// Valid/ready channel carrying one word of payload type T.
interface tpcs_chan_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/two_process_cpu_scheduler_tick.sv =====
// Two-process CPU scheduler, one tick per input word.
//
//   channel      dir  payload                      handshake
//   i_in_chan    in   restart                      valid/ready
//   o_out_chan   out  code_a, code_b, all_done     valid/ready
//   i_cfg_*      in   index 0..7, 8-bit data       write enable only
//
// One word a cycle while the output is taken: a tick is one pass of the next-state
// logic between the input register and the state/result registers.
// Reset (synchronous, active low) loads the register defaults and the state
// that follows from them. A stalled output holds its word; the input register
// still takes one more word and then holds off until the result is taken.
module two_process_cpu_scheduler_tick
    import tpcs_pkg::*;
#(
    parameter int COUNT_WIDTH = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tpcs_chan_if.sink             i_in_chan,
    tpcs_chan_if.source           o_out_chan,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg cfg;

    logic r_in_valid;
    logic r_in_restart;
    logic advance;

    t_pstate                r_state_a, r_state_b;
    logic [COUNT_WIDTH-1:0] r_cpu_a, r_cpu_b, r_io_a, r_io_b, r_slice;

    t_pstate                n_state_a, n_state_b;
    logic [COUNT_WIDTH-1:0] n_cpu_a, n_cpu_b, n_io_a, n_io_b, n_slice;
    t_out                   n_result;

    logic r_out_valid;
    t_out r_out_data;

    tpcs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    tpcs_step #(
        .CW (COUNT_WIDTH)
    ) u_step (
        .i_restart (r_in_restart),
        .i_cfg     (cfg),
        .i_state_a (r_state_a),
        .i_state_b (r_state_b),
        .i_cpu_a   (r_cpu_a),
        .i_cpu_b   (r_cpu_b),
        .i_io_a    (r_io_a),
        .i_io_b    (r_io_b),
        .i_slice   (r_slice),
        .o_state_a (n_state_a),
        .o_state_b (n_state_b),
        .o_cpu_a   (n_cpu_a),
        .o_cpu_b   (n_cpu_b),
        .o_io_a    (n_io_a),
        .o_io_b    (n_io_b),
        .o_slice   (n_slice),
        .o_result  (n_result)
    );

    // advance the held word when the result register is free or being emptied
    assign advance         = r_in_valid && (!r_out_valid || o_out_chan.ready);
    assign i_in_chan.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_in_valid <= i_in_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.ready && i_in_chan.valid) begin
            r_in_restart <= i_in_chan.data.restart;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state_a <= ST_READY;
            r_state_b <= ST_READY;
            r_cpu_a   <= COUNT_WIDTH'(RST_CPU);
            r_cpu_b   <= COUNT_WIDTH'(RST_CPU);
            r_io_a    <= COUNT_WIDTH'(RST_IO);
            r_io_b    <= COUNT_WIDTH'(RST_IO);
            r_slice   <= COUNT_WIDTH'(RST_QUANTUM);
        end else if (advance) begin
            r_state_a <= n_state_a;
            r_state_b <= n_state_b;
            r_cpu_a   <= n_cpu_a;
            r_cpu_b   <= n_cpu_b;
            r_io_a    <= n_io_a;
            r_io_b    <= n_io_b;
            r_slice   <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out_chan.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_result;
        end
    end

    assign o_out_chan.valid = r_out_valid;
    assign o_out_chan.data  = r_out_data;

    a_one_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data.code_a == ST_RUN && r_out_data.code_b == ST_RUN))
        else $error("both processes reported running");

    a_all_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.all_done ==
                         (r_out_data.code_a == ST_DONE && r_out_data.code_b == ST_DONE)))
        else $error("all_done disagrees with the state codes");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_restart)))
        else $error("held input word lost while stalled");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced word gave no result");

    a_state_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_state_a) && $stable(r_state_b) && $stable(r_slice)))
        else $error("scheduler state moved without a tick");

endmodule

// ===== design/tpcs_cfg_regs.sv =====
// Configuration register file: policy, quantum and burst lengths.
module tpcs_cfg_regs
    import tpcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.policy       <= RST_POLICY;
            r_cfg.quantum      <= RST_QUANTUM;
            r_cfg.first_cpu_a  <= RST_CPU;
            r_cfg.io_a         <= RST_IO;
            r_cfg.second_cpu_a <= RST_CPU;
            r_cfg.first_cpu_b  <= RST_CPU;
            r_cfg.io_b         <= RST_IO;
            r_cfg.second_cpu_b <= RST_CPU;
        end else if (i_wr_en) begin
            unique case (i_index)
                REG_POLICY:       r_cfg.policy       <= i_wdata[1:0];
                REG_QUANTUM:      r_cfg.quantum      <= i_wdata;
                REG_FIRST_CPU_A:  r_cfg.first_cpu_a  <= i_wdata;
                REG_IO_A:         r_cfg.io_a         <= i_wdata;
                REG_SECOND_CPU_A: r_cfg.second_cpu_a <= i_wdata;
                REG_FIRST_CPU_B:  r_cfg.first_cpu_b  <= i_wdata;
                REG_IO_B:         r_cfg.io_b         <= i_wdata;
                REG_SECOND_CPU_B: r_cfg.second_cpu_b <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/tpcs_step.sv =====
// Next-state logic for one scheduler tick: completion, slice, IO, dispatch, count down.
module tpcs_step
    import tpcs_pkg::*;
#(
    parameter int CW = 8
) (
    input  logic    i_restart,
    input  t_cfg    i_cfg,
    input  t_pstate i_state_a,
    input  t_pstate i_state_b,
    input  logic [CW-1:0] i_cpu_a,
    input  logic [CW-1:0] i_cpu_b,
    input  logic [CW-1:0] i_io_a,
    input  logic [CW-1:0] i_io_b,
    input  logic [CW-1:0] i_slice,
    output t_pstate o_state_a,
    output t_pstate o_state_b,
    output logic [CW-1:0] o_cpu_a,
    output logic [CW-1:0] o_cpu_b,
    output logic [CW-1:0] o_io_a,
    output logic [CW-1:0] o_io_b,
    output logic [CW-1:0] o_slice,
    output t_out    o_result
);

    localparam int LW = (CW > 8) ? CW : 8;

    // Load an 8-bit length into a counter, saturating when the counter is narrower
    function automatic logic [CW-1:0] load_cnt(input logic [7:0] v);
        logic [LW-1:0] wide;
        logic [LW-1:0] cmax;
        wide = LW'(v);
        cmax = LW'({CW{1'b1}});
        return (wide > cmax) ? {CW{1'b1}} : wide[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] v);
        return (v == '0) ? v : v - CW'(1);
    endfunction

    t_pstate       sa, sb;
    logic [CW-1:0] ca, cb, ia, ib, sl, q;

    always_comb begin
        sa = i_state_a;
        sb = i_state_b;
        ca = i_cpu_a;
        cb = i_cpu_b;
        ia = i_io_a;
        ib = i_io_b;
        sl = i_slice;

        if (i_restart) begin
            sa = ST_READY;
            sb = ST_READY;
            ca = load_cnt(i_cfg.first_cpu_a);
            ia = load_cnt(i_cfg.io_a);
            cb = load_cnt(i_cfg.first_cpu_b);
            ib = load_cnt(i_cfg.io_b);
            sl = load_cnt(i_cfg.quantum);
        end
        q = load_cnt(i_cfg.quantum);

        // burst completion, A first, at most one per tick
        if (sa == ST_RUN && ca == '0) begin
            sa = (ia == '0) ? ST_DONE : ST_WAIT;
        end else if (sb == ST_RUN && cb == '0) begin
            sb = (ib == '0) ? ST_DONE : ST_WAIT;
        end

        // slice expiry under round robin
        if (i_cfg.policy == POL_RR) begin
            if (sa == ST_RUN && sl == '0) begin
                sa = ST_READY;
                sl = q;
                if (sb == ST_READY) sb = ST_RUN;
            end
            if (sb == ST_RUN && sl == '0) begin
                sb = ST_READY;
                sl = q;
                if (sa == ST_READY) sa = ST_RUN;
            end
        end

        // IO completion, with preemption of the other process under SRTF
        if (sa == ST_WAIT && ia == '0) begin
            ca = load_cnt(i_cfg.second_cpu_a);
            if (i_cfg.policy == POL_SRTF && ca < cb && (sb == ST_RUN || sb == ST_READY)) begin
                sa = ST_RUN;
                sb = ST_READY;
            end else begin
                sa = ST_READY;
            end
        end
        if (sb == ST_WAIT && ib == '0) begin
            cb = load_cnt(i_cfg.second_cpu_b);
            if (i_cfg.policy == POL_SRTF && cb < ca && (sa == ST_RUN || sa == ST_READY)) begin
                sb = ST_RUN;
                sa = ST_READY;
            end else begin
                sb = ST_READY;
            end
        end

        // dispatch onto a free CPU
        if (sa == ST_READY && sb == ST_READY) begin
            if (i_cfg.policy == POL_FCFS || i_cfg.policy == POL_RR || ca <= cb) begin
                sa = ST_RUN;
            end else begin
                sb = ST_RUN;
            end
            sl = q;
        end else if (sa == ST_READY && sb != ST_RUN) begin
            sa = ST_RUN;
            sl = q;
        end else if (sb == ST_READY && sa != ST_RUN) begin
            sb = ST_RUN;
            sl = q;
        end

        o_result.code_a   = sa;
        o_result.code_b   = sb;
        o_result.all_done = (sa == ST_DONE) && (sb == ST_DONE);

        // count down
        o_state_a = sa;
        o_state_b = sb;
        o_slice   = dec_sat(sl);
        o_cpu_a   = (sa == ST_RUN)  ? dec_sat(ca) : ca;
        o_io_a    = (sa == ST_WAIT) ? dec_sat(ia) : ia;
        o_cpu_b   = (sb == ST_RUN)  ? dec_sat(cb) : cb;
        o_io_b    = (sb == ST_WAIT) ? dec_sat(ib) : ib;
    end

endmodule
